### rtl/sliding_median_filter_unit_assert.svh
// assertion macros for the sliding median filter
`ifndef SLIDING_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/smf_pkg.sv
`default_nettype none

package smf_pkg;

    localparam int WINDOW_LEN  = 7;
    localparam int SAMPLE_BITS = 16;
    // rank of the median in the sorted window, counting from zero
    localparam int MEDIAN_RANK = WINDOW_LEN / 2;
    localparam int RANK_BITS   = $clog2(WINDOW_LEN);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [WINDOW_LEN-1:0]      window_t;
    typedef logic [RANK_BITS-1:0]          rank_t;

endpackage

`default_nettype wire

### rtl/smf_window.sv
`default_nettype none

module smf_window
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire smf_pkg::sample_t sample,
    output smf_pkg::window_t     window
);
    import smf_pkg::*;

    window_t window_reg;
    window_t window_next;

    // entry zero is the oldest sample, the top entry the newest
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[WINDOW_LEN-1] = sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

    assign window = window_reg;

endmodule

`default_nettype wire

### rtl/smf_rank_select.sv
`default_nettype none

module smf_rank_select
(
    input  smf_pkg::window_t window,
    output smf_pkg::sample_t median
);
    import smf_pkg::*;

    logic [WINDOW_LEN-1:0] hit;
    sample_t               pick;

    // rank of entry i: entries strictly below it, plus equal entries at a
    // lower index, so ties get distinct ranks and exactly one entry hits
    always_comb
    begin
        logic [WINDOW_LEN-1:0] below;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                below[j] = ($signed(window[j]) < $signed(window[i]))
                        || ((j < i) && (window[j] == window[i]));
            end
            hit[i] = (RANK_BITS'($countones(below)) == RANK_BITS'(MEDIAN_RANK));
        end
    end

    // one-hot and-or select
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            pick = pick | (window[i] & {SAMPLE_BITS{hit[i]}});
        end
    end

    assign median = pick;

endmodule

`default_nettype wire

### rtl/sliding_median_filter_unit.sv
// sliding median filter: each sample beat is shifted into a window of the
// seven most recent samples (signed, 16 bits) and one median beat comes out
// per sample, the fourth-smallest value of the window including the new
// sample; the window resets to zeros, which count like real samples until
// seven samples have arrived. throughput is one sample per clock while
// sample_stall is low. the window register doubles as the input stage, a
// rank-and-select compare network sits between it and the median register,
// and a stall on the median side holds the window and backs up to
// sample_stall only when both stages are full.
`default_nettype none

module sliding_median_filter_unit
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_stall,
    input  wire smf_pkg::sample_t sample,
    output logic                 median_valid,
    input  wire logic            median_stall,
    output smf_pkg::sample_t     median
);
    import smf_pkg::*;

    `include "sliding_median_filter_unit_assert.svh"

    // window stage holds a beat whose median is not yet registered
    logic    win_valid_reg;
    logic    win_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t median_reg;

    logic    in_take;
    logic    out_load;
    window_t window;
    sample_t median_calc;

    // median register can take a new value when empty or being drained
    assign out_load     = !out_valid_reg || !median_stall;
    assign sample_stall = win_valid_reg && !out_load;
    assign in_take      = sample_valid && !sample_stall;

    smf_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_take),
        .sample   (sample),
        .window   (window)
    );

    smf_rank_select u_rank_select
    (
        .window (window),
        .median (median_calc)
    );

    always_comb
    begin
        win_valid_next = win_valid_reg;
        if (in_take)
        begin
            win_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            win_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = win_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= win_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load && win_valid_reg)
        begin
            median_reg <= median_calc;
        end
    end

    assign median_valid = out_valid_reg;
    assign median       = median_reg;

    // back-pressure only with both stages occupied
    `SMF_ASSERT_NOW(a_stall_needs_full, sample_stall, win_valid_reg && out_valid_reg, "stall with a free stage")
    // a window beat moving forward shows up as a median beat
    `SMF_ASSERT_NEXT(a_window_to_output, win_valid_reg && out_load, median_valid, "window beat lost")
    // a taken sample is held in the window stage next cycle
    `SMF_ASSERT_NEXT(a_take_fills_window, in_take, win_valid_reg, "sample beat lost")

endmodule

`default_nettype wire
